>>> src/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types for the integer matrix multiply unit: controller states and
// the operand flow handed from cell to cell along the MAC chain.
// ----------------------------------------------------------------------------
package imm_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FEED,
    ST_WAIT,
    ST_EMIT,
    ST_MISMATCH
  } imm_state_t;

  typedef struct packed {
    logic        valid;
    logic        first;
    logic        last;
    logic [31:0] a;
  } imm_flow_t;

endpackage

>>> src/imm_entry_if.sv
// ----------------------------------------------------------------------------
// imm_entry_if
// Valid/ready channel that carries one matrix entry per transaction.
// ----------------------------------------------------------------------------
interface imm_entry_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] entry_value;

  modport source (output valid, output entry_value, input ready);
  modport sink   (input valid, input entry_value, output ready);
endinterface

>>> src/imm_product_if.sv
// ----------------------------------------------------------------------------
// imm_product_if
// Valid/ready channel that carries one product element per transaction.
// ----------------------------------------------------------------------------
interface imm_product_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] product_value;
  logic               row_end;
  logic               last_item;
  logic               dims_mismatch;

  modport source (output valid, output product_value, output row_end,
                  output last_item, output dims_mismatch, input ready);
  modport sink   (input valid, input product_value, input row_end,
                  input last_item, input dims_mismatch, output ready);
endinterface

>>> src/imm_cell.sv
// ----------------------------------------------------------------------------
// imm_cell
// One MAC cell of the chain. Holds one column of B, multiplies the passing
// A entry by its B element, accumulates the dot product and forwards the A
// entry to its neighbor. Results shift toward cell 0 for output.
// ----------------------------------------------------------------------------
module imm_cell #(
  parameter int MAX_DIM = 8,
  parameter int COL     = 0,
  parameter int K_W     = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  imm_pkg::imm_flow_t  flow_in,
  input  logic [K_W-1:0]      k_in,
  output imm_pkg::imm_flow_t  flow_out,
  output logic [K_W-1:0]      k_out,
  input  logic                bwr_en,
  input  logic [K_W-1:0]      bwr_row,
  input  logic [K_W-1:0]      bwr_col,
  input  logic [31:0]         bwr_data,
  input  logic                load_res,
  input  logic                shift_res,
  input  logic [31:0]         res_in,
  output logic [31:0]         res_out,
  output logic                done
);
  import imm_pkg::*;

  logic [31:0] bcol [MAX_DIM];
  logic [31:0] prod;
  logic        pvalid;
  logic        pfirst;
  logic        plast;
  logic [31:0] acc;

  // store the B element of this column
  always_ff @(posedge clk) begin
    if (bwr_en && bwr_col == K_W'(COL)) begin
      bcol[bwr_row] <= bwr_data;
    end
  end

  // multiply and forward the A entry
  always_ff @(posedge clk) begin
    prod       <= 32'(flow_in.a * bcol[k_in]);
    pfirst     <= flow_in.first;
    plast      <= flow_in.last;
    flow_out.a     <= flow_in.a;
    flow_out.first <= flow_in.first;
    flow_out.last  <= flow_in.last;
    k_out      <= k_in;
    if (rst) begin
      pvalid         <= 1'b0;
      flow_out.valid <= 1'b0;
    end else begin
      pvalid         <= flow_in.valid;
      flow_out.valid <= flow_in.valid;
    end
  end

  // accumulate the dot product, flag the final term
  always_ff @(posedge clk) begin
    if (pvalid) begin
      acc <= pfirst ? prod : acc + prod;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pvalid && plast;
    end
  end

  // capture the result, then shift toward the output
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_out <= acc;
    end else if (shift_res) begin
      res_out <= res_in;
    end
  end

endmodule

>>> src/integer_matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Loads A then B one entry per transaction on the entry channel and returns
// A*B in row-major order on the product channel, sums wrapped to 32 bits.
// ----------------------------------------------------------------------------
// Usage:
//   Program rows_a, cols_a, rows_b, cols_b over APB (byte addresses 0,4,8,12)
//   while the block is idle; any write restarts the load with A. Values of
//   0 act as 1, values above MAX_DIM act as MAX_DIM.
//   Entries are taken one per cycle while loading. After the last B entry
//   the entry channel stalls until the whole answer has been taken.
//   If cols_a != rows_b one result with dims_mismatch set comes out.
//   Otherwise each product row is computed in a chain of MAX_DIM MAC cells,
//   cell j holding column j of B; the cols_a entries of row i are fed in
//   serially, drain through the whole chain, then its cols_b elements leave
//   one per cycle unless the product channel stalls.
//   A stall on the product channel holds the current element.
//   Reset (rst, synchronous) sets all dimensions to 1 and clears the load.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic           clk,
  input  logic           rst,
  imm_entry_if.sink      entry,
  imm_product_if.source  product,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import imm_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int K_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(2 * DEPTH + 1);

  localparam logic [1:0] REG_ROWS_A = 2'd0;
  localparam logic [1:0] REG_COLS_A = 2'd1;
  localparam logic [1:0] REG_ROWS_B = 2'd2;
  localparam logic [1:0] REG_COLS_B = 2'd3;

  logic [3:0] rows_a, cols_a, rows_b, cols_b;
  logic [DIM_W-1:0] ra, ca, rb, cb;
  logic [2*DIM_W-1:0] na, nb;
  logic [CW-1:0] total;

  imm_state_t state, state_next;
  logic [CW-1:0]  cnt;
  logic [K_W-1:0] bk, bj, k, i, oj;
  logic [AW-1:0]  row_base;
  logic [31:0]    amem [DEPTH];
  logic [31:0]    rd_data;
  logic           f_valid, f_first, f_last;
  logic [K_W-1:0] f_k;

  logic cfg_wr, in_acc, out_acc, load_done, bwr_en, load_res, shift_res;
  logic feed_last, emit_row_end, emit_last_row;

  imm_flow_t      flow  [MAX_DIM+1];
  logic [K_W-1:0] kch   [MAX_DIM+1];
  logic [31:0]    res_ch[MAX_DIM+1];
  logic           done  [MAX_DIM];

  function automatic logic [DIM_W-1:0] eff_dim(input logic [3:0] v);
    if (v == 4'd0) begin
      return DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  // effective dimensions and load length
  always_comb begin
    ra    = eff_dim(rows_a);
    ca    = eff_dim(cols_a);
    rb    = eff_dim(rows_b);
    cb    = eff_dim(cols_b);
    na    = ra * ca;
    nb    = rb * cb;
    total = CW'(na) + CW'(nb);
  end

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a <= 4'd1;
      cols_a <= 4'd1;
      rows_b <= 4'd1;
      cols_b <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROWS_A: rows_a <= pwdata[3:0];
        REG_COLS_A: cols_a <= pwdata[3:0];
        REG_ROWS_B: rows_b <= pwdata[3:0];
        REG_COLS_B: cols_b <= pwdata[3:0];
        default:    rows_a <= rows_a;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROWS_A: prdata = {28'd0, rows_a};
      REG_COLS_A: prdata = {28'd0, cols_a};
      REG_ROWS_B: prdata = {28'd0, rows_b};
      REG_COLS_B: prdata = {28'd0, cols_b};
      default:    prdata = 32'd0;
    endcase
  end

  // handshake and control terms
  assign entry.ready   = (state == ST_LOAD);
  assign in_acc        = entry.valid && entry.ready;
  assign out_acc       = product.valid && product.ready;
  assign load_done     = in_acc && (cnt + CW'(1) == total);
  assign bwr_en        = in_acc && (cnt >= CW'(na));
  assign feed_last     = (DIM_W'(k) == ca - DIM_W'(1));
  assign emit_row_end  = (DIM_W'(oj) == cb - DIM_W'(1));
  assign emit_last_row = (DIM_W'(i) == ra - DIM_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (load_done) begin
          state_next = (ca != rb) ? ST_MISMATCH : ST_FEED;
        end
      end
      ST_FEED: begin
        if (feed_last) state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (done[MAX_DIM-1]) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc && emit_row_end) begin
          state_next = emit_last_row ? ST_LOAD : ST_FEED;
        end
      end
      ST_MISMATCH: begin
        if (out_acc) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    load_res              = 1'b0;
    shift_res             = 1'b0;
    product.valid         = 1'b0;
    product.product_value = res_ch[0];
    product.row_end       = 1'b0;
    product.last_item     = 1'b0;
    product.dims_mismatch = 1'b0;
    unique case (state)
      ST_WAIT: load_res = done[MAX_DIM-1];
      ST_EMIT: begin
        product.valid     = 1'b1;
        product.row_end   = emit_row_end;
        product.last_item = emit_row_end && emit_last_row;
        shift_res         = out_acc;
      end
      ST_MISMATCH: begin
        product.valid         = 1'b1;
        product.product_value = 32'sd0;
        product.last_item     = 1'b1;
        product.dims_mismatch = 1'b1;
      end
      default: load_res = 1'b0;
    endcase
  end

  // state register and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      cnt      <= '0;
      bk       <= '0;
      bj       <= '0;
      k        <= '0;
      i        <= '0;
      oj       <= '0;
      row_base <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr || load_done) begin
        cnt <= '0;
        bk  <= '0;
        bj  <= '0;
      end else if (in_acc) begin
        cnt <= cnt + CW'(1);
        if (bwr_en) begin
          if (DIM_W'(bj) == cb - DIM_W'(1)) begin
            bj <= '0;
            bk <= bk + K_W'(1);
          end else begin
            bj <= bj + K_W'(1);
          end
        end
      end
      if (load_done) begin
        i        <= '0;
        k        <= '0;
        row_base <= '0;
      end
      if (state == ST_FEED) begin
        k <= feed_last ? '0 : k + K_W'(1);
      end
      if (load_res) begin
        oj <= '0;
      end else if (shift_res) begin
        oj <= oj + K_W'(1);
        if (emit_row_end && !emit_last_row) begin
          i        <= i + K_W'(1);
          row_base <= row_base + AW'(ca);
        end
      end
    end
  end

  // A store: write while loading, read one entry per cycle while feeding
  always_ff @(posedge clk) begin
    if (in_acc && !bwr_en) begin
      amem[cnt[AW-1:0]] <= entry.entry_value;
    end
    rd_data <= amem[row_base + AW'(k)];
  end

  // align flow tags with the registered read data
  always_ff @(posedge clk) begin
    f_first <= (k == '0);
    f_last  <= feed_last;
    f_k     <= k;
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= (state == ST_FEED);
    end
  end

  assign flow[0].valid  = f_valid;
  assign flow[0].first  = f_first;
  assign flow[0].last   = f_last;
  assign flow[0].a      = rd_data;
  assign kch[0]         = f_k;
  assign res_ch[MAX_DIM] = 32'd0;

  // chain of MAC cells, one per column of B
  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    imm_cell #(
      .MAX_DIM (MAX_DIM),
      .COL     (j),
      .K_W     (K_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .flow_in   (flow[j]),
      .k_in      (kch[j]),
      .flow_out  (flow[j+1]),
      .k_out     (kch[j+1]),
      .bwr_en    (bwr_en),
      .bwr_row   (bk),
      .bwr_col   (bj),
      .bwr_data  (entry.entry_value),
      .load_res  (load_res),
      .shift_res (shift_res),
      .res_in    (res_ch[j+1]),
      .res_out   (res_ch[j]),
      .done      (done[j])
    );
  end

endmodule

>>> tb/integer_matrix_multiply_unit_tb.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit_tb
// Self-checking bench for the matrix multiply unit. Dimensions are programmed
// over APB, entries stream in on the entry channel, and every product
// transaction is checked against a behavioral predictor of A*B. A directed
// table covers extremes, the mismatch answer, saturated dimensions and a
// restart by register write. Random phases with varying dimensions and
// traffic shapes follow.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imm_pkg::*;

  localparam int MAX_DIM      = 8;
  localparam int SETTLE_CYCS  = 300;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TARGET_ITEMS = 400;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    REG_ROWS_A = 0,
    REG_COLS_A = 1,
    REG_ROWS_B = 2,
    REG_COLS_B = 3
  } reg_idx_t;

  typedef enum int {
    ROW_ENTRY,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    logic signed [31:0] value;
    logic               row_end;
    logic               last_item;
    logic               dims_mismatch;
  } product_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] value;
    bit          typed;
    product_t    result;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  imm_entry_if   entry_ch ();
  imm_product_if product_ch ();

  integer_matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk     (clk),
    .rst     (rst),
    .entry   (entry_ch),
    .product (product_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [3:0]  dim_reg [4];
  logic [31:0] a_store [64];
  logic [31:0] b_store [64];
  logic [7:0]  load_cnt;
  product_t    product_q [$];

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_cycles   = 0;
  int errors        = 0;
  int entries_sent  = 0;
  int results_seen  = 0;
  int answers       = 0;
  int mismatches    = 0;
  int idle_cnt      = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int eff_dim(logic [3:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // update the predictor with one accepted entry, queue any answer it causes
  task automatic predict_entry(logic [31:0] v);
    int ra, ca, rb, cb, na, nb;
    logic [31:0] sum;
    product_t p;
    ra = eff_dim(dim_reg[REG_ROWS_A]);
    ca = eff_dim(dim_reg[REG_COLS_A]);
    rb = eff_dim(dim_reg[REG_ROWS_B]);
    cb = eff_dim(dim_reg[REG_COLS_B]);
    na = ra * ca;
    nb = rb * cb;
    if (load_cnt < na) a_store[load_cnt[5:0]] = v;
    else b_store[(load_cnt - na) & 63] = v;
    load_cnt = load_cnt + 1;
    if (load_cnt < na + nb) return;
    load_cnt = '0;
    answers++;
    if (ca != rb) begin
      mismatches++;
      p = '{32'sd0, 1'b0, 1'b1, 1'b1};
      product_q.insert(product_q.size(), p);
      return;
    end
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        sum = '0;
        for (int k = 0; k < ca; k++) sum = sum + a_store[i*ca+k] * b_store[k*cb+j];
        p.value         = sum;
        p.row_end       = (j == cb - 1);
        p.last_item     = (i == ra - 1) && (j == cb - 1);
        p.dims_mismatch = 1'b0;
        product_q.insert(product_q.size(), p);
      end
    end
  endtask

  // APB write: setup then access, register taken at the access edge
  task automatic apb_write(reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 4'(idx * 4); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    dim_reg[idx] = v[3:0];
    load_cnt = '0;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // APB read and compare with the bits last written
  task automatic apb_check(reg_idx_t idx);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b0; penable = 1'b0; paddr = 4'(idx * 4);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {28'd0, dim_reg[idx]}) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("register %0d readback: expected %0h, got %0h", idx, dim_reg[idx], prdata);
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  // offer one entry, hold it until the transaction completes
  task automatic send_entry(logic [31:0] v, bit typed, product_t t);
    while ($urandom_range(99) < snd_idle_pct) begin
      entry_ch.valid = 1'b0;
      @(negedge clk);
    end
    entry_ch.valid       = 1'b1;
    entry_ch.entry_value = v;
    do @(posedge clk); while (!entry_ch.ready);
    predict_entry(v);
    if (typed) product_q[product_q.size()-1] = t;
    entries_sent++;
    @(negedge clk);
  endtask

  // drop valid, drain every expected product, then let the block go quiet
  task automatic settle();
    entry_ch.valid = 1'b0;
    while (product_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCS) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_entry();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 32'h8000_0000;
    if (pick == 1) return 32'h7fff_ffff;
    if (pick < 6) return 32'($signed($urandom_range(16)) - 8);
    return $urandom;
  endfunction

  // receiver ready, with an optional long hold counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      product_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      product_ch.ready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // check product transactions, run the watchdog
  always @(posedge clk) begin
    product_t e;
    if (!rst) begin
      if (product_ch.valid && product_ch.ready) begin
        results_seen++;
        if (product_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected product transaction: %0d", product_ch.product_value);
        end else begin
          e = product_q.pop_front();
          if (product_ch.product_value !== e.value || product_ch.row_end !== e.row_end ||
              product_ch.last_item !== e.last_item ||
              product_ch.dims_mismatch !== e.dims_mismatch) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("product mismatch: expected %0d/%b/%b/%b, got %0d/%b/%b/%b",
                       e.value, e.row_end, e.last_item, e.dims_mismatch,
                       product_ch.product_value, product_ch.row_end,
                       product_ch.last_item, product_ch.dims_mismatch);
          end
        end
      end
      if ((product_ch.valid && product_ch.ready) || (entry_ch.valid && entry_ch.ready))
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("integer_matrix_multiply_unit regression: fail");
        $finish;
      end
    end
  end

  stim_row_t dir_tab [$];

  task automatic add_entry(logic [31:0] v);
    stim_row_t r;
    r = '{ROW_ENTRY, REG_ROWS_A, v, 1'b0, '{0, 0, 0, 0}};
    dir_tab.insert(dir_tab.size(), r);
  endtask

  task automatic add_typed(logic [31:0] v, product_t t);
    stim_row_t r;
    r = '{ROW_ENTRY, REG_ROWS_A, v, 1'b1, t};
    dir_tab.insert(dir_tab.size(), r);
  endtask

  task automatic add_cfg(reg_idx_t idx, logic [31:0] v);
    stim_row_t r;
    r = '{ROW_CFG, idx, v, 1'b0, '{0, 0, 0, 0}};
    dir_tab.insert(dir_tab.size(), r);
  endtask

  initial begin
    int ra, ca, rb, cb, n, sets, partial, phase;
    logic [3:0] dims [4];
    entry_ch.valid       = 1'b0;
    entry_ch.entry_value = '0;
    product_ch.ready     = 1'b0;
    for (int i = 0; i < 4; i++) dim_reg[i] = 4'd1;
    for (int i = 0; i < 64; i++) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
    load_cnt = '0;

    // reset
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 1x1 products at the extremes
    add_entry(32'h7fff_ffff);
    add_typed(32'h7fff_ffff, '{32'sd1, 1'b1, 1'b1, 1'b0});
    add_entry(32'h8000_0000);
    add_typed(32'hffff_ffff, '{32'sh8000_0000, 1'b1, 1'b1, 1'b0});
    add_entry(32'h0000_0000);
    add_typed(32'hffff_ffff, '{32'sd0, 1'b1, 1'b1, 1'b0});
    // 1x2 by 1x1: dimension mismatch
    add_cfg(REG_COLS_A, 32'd2);
    add_entry(32'd5);
    add_entry(32'd6);
    add_typed(32'd7, '{32'sd0, 1'b0, 1'b1, 1'b1});
    // zero acts as one, fifteen saturates to eight: 1x1 by 1x8
    add_cfg(REG_COLS_A, 32'd1);
    add_cfg(REG_ROWS_A, 32'd0);
    add_cfg(REG_COLS_B, 32'd15);
    for (int i = 0; i < 9; i++) add_entry(rand_entry());
    // a write in the middle of a load restarts it with A
    add_entry(32'h1234_5678);
    add_entry(32'h8765_4321);
    add_cfg(REG_COLS_B, 32'd15);
    for (int i = 0; i < 9; i++) add_entry(rand_entry());

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        apb_write(dir_tab[i].idx, dir_tab[i].value);
        apb_check(dir_tab[i].idx);
      end else begin
        send_entry(dir_tab[i].value, dir_tab[i].typed, dir_tab[i].result);
      end
    end
    settle();

    // random phases
    phase = 0;
    while (entries_sent < TARGET_ITEMS) begin
      case (phase)
        0: dims = '{4'd1, 4'd1, 4'd1, 4'd1};
        1: dims = '{4'd8, 4'd8, 4'd8, 4'd8};
        2: dims = '{4'd2, 4'd3, 4'd3, 4'd4};
        3: dims = '{4'd3, 4'd4, 4'd5, 4'd2};
        4: dims = '{4'd15, 4'd1, 4'd0, 4'd8};
        5: dims = '{4'd1, 4'd8, 4'd8, 4'd1};
        default: begin
          for (int i = 0; i < 4; i++) dims[i] = 4'($urandom_range(15));
          if ($urandom_range(3) != 0) dims[REG_ROWS_B] = dims[REG_COLS_A];
          if ($urandom_range(1) == 0) begin
            dims[REG_ROWS_A] = 4'($urandom_range(1, 3));
            dims[REG_COLS_B] = 4'($urandom_range(1, 3));
          end
        end
      endcase
      case (phase % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
        default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
      endcase

      // start a load under the old setting, then abandon it by writing
      if (phase % 3 == 1) begin
        n = eff_dim(dim_reg[REG_ROWS_A]) * eff_dim(dim_reg[REG_COLS_A]) +
            eff_dim(dim_reg[REG_ROWS_B]) * eff_dim(dim_reg[REG_COLS_B]);
        partial = (n > 1) ? $urandom_range(n - 1, 1) : 0;
        for (int i = 0; i < partial; i++) send_entry(rand_entry(), 1'b0, '{0, 0, 0, 0});
        settle();
      end
      for (int i = 0; i < 4; i++) apb_write(reg_idx_t'(i), {$urandom} << 4 | dims[i]);
      for (int i = 0; i < 4; i++) apb_check(reg_idx_t'(i));

      ra = eff_dim(dims[REG_ROWS_A]);
      ca = eff_dim(dims[REG_COLS_A]);
      rb = eff_dim(dims[REG_ROWS_B]);
      cb = eff_dim(dims[REG_COLS_B]);
      n = ra * ca + rb * cb;
      sets = (n >= 40) ? 1 : 40 / n;
      // hold the receiver off so the block fills and stalls its input
      if (phase == 2) hold_cycles = 600;
      for (int s = 0; s < sets; s++) begin
        for (int i = 0; i < n; i++) send_entry(rand_entry(), 1'b0, '{0, 0, 0, 0});
        // pause the sender until the whole answer is out
        if (phase == 3) begin
          entry_ch.valid = 1'b0;
          while (product_q.size() != 0) @(posedge clk);
          @(negedge clk);
        end
      end
      settle();
      phase++;
    end

    $display("covered %0d entries, %0d answers (%0d mismatched), %0d products checked",
             entries_sent, answers, mismatches, results_seen);
    $display("over %0d dimension settings with varied sender and receiver idling", phase + 4);
    if (errors == 0 && product_q.size() == 0) begin
      $display("integer_matrix_multiply_unit regression: pass");
    end else begin
      $display("integer_matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
